@@ hdl/led_flash_state_resolver_defines.svh @@
// assertion macros for the led flash state resolver
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef LED_FLASH_STATE_RESOLVER_DEFINES_SVH
`define LED_FLASH_STATE_RESOLVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define LEDFSR_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LEDFSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LEDFSR_ASSERT_HOLDS(label, ante, cons, msg)
`define LEDFSR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/ledfsr_pkg.sv @@
// types and constants for the led flash state resolver
// no dependencies
package ledfsr_pkg;

  // one unit of on, off or lifetime is this many milliseconds
  localparam logic [6:0] MS_PER_UNIT = 7'd100;

  // permanent block control codes
  localparam logic [7:0] PERM_CODE_SET = 8'd1;

  // temporary block control codes
  localparam logic [7:0] TEMP_CODE_CANCEL = 8'd1;
  localparam logic [7:0] TEMP_CODE_SET    = 8'd2;

  // port widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 1;

  // input item data, lowest field last
  typedef struct packed {
    logic [15:0] temp_timer_units;
    logic [7:0]  temp_off_units;
    logic [7:0]  temp_on_units;
    logic [7:0]  temp_off_colour;
    logic [7:0]  temp_on_colour;
    logic [7:0]  perm_off_units;
    logic [7:0]  perm_on_units;
    logic [7:0]  perm_off_colour;
    logic [7:0]  perm_on_colour;
    logic [31:0] now_ms;
  } item_data_t;

  // input item codes, lowest field last
  typedef struct packed {
    logic [7:0] temp_code;
    logic [7:0] perm_code;
  } item_user_t;

endpackage

@@ hdl/led_flash_state_resolver.sv @@
// An accepted item passes S_APPLY, S_SELECT, the S_DIVIDE loop (skipped with a zero period)
// and S_DONE, which registers the result once the output register has room; the 32-step
// restoring remainder loop of the phase unit, one dividend bit per cycle, is the longest step.
// A new item is taken only in S_IDLE, once the last is registered; a finished result waits
// in the output register while the next item is accepted. Reset (rst_n low, synchronous):
// both blocks black with zero times, temporary block not armed, output empty.
`include "led_flash_state_resolver_defines.svh"

module led_flash_state_resolver (
  input  logic                                clk,
  input  logic                                rst_n,
  // now_ms, perm_on_colour, perm_off_colour, perm_on_units, perm_off_units,
  // temp_on_colour, temp_off_colour, temp_on_units, temp_off_units, temp_timer_units
  input  logic [ledfsr_pkg::IN_DATA_W-1:0]   in_tdata,
  // perm_code, temp_code
  input  logic [ledfsr_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // shown_color
  output logic [ledfsr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // temp_showing
  output logic [ledfsr_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import ledfsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SELECT,
    S_DIVIDE,
    S_DONE
  } state_t;

  // sequencer
  state_t      state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // latched item
  item_data_t  item_r, item_nxt;
  item_user_t  code_r, code_nxt;

  // stored blocks
  logic [7:0]  perm_on_col_r, perm_on_col_nxt;
  logic [7:0]  perm_off_col_r, perm_off_col_nxt;
  logic [7:0]  perm_on_time_r, perm_on_time_nxt;
  logic [7:0]  perm_off_time_r, perm_off_time_nxt;
  logic [7:0]  tmp_on_col_r, tmp_on_col_nxt;
  logic [7:0]  tmp_off_col_r, tmp_off_col_nxt;
  logic [7:0]  tmp_on_time_r, tmp_on_time_nxt;
  logic [7:0]  tmp_off_time_r, tmp_off_time_nxt;
  logic        tmp_active_r, tmp_active_nxt;
  logic [31:0] tmp_start_ms_r, tmp_start_ms_nxt;
  logic [22:0] tmp_duration_ms_r, tmp_duration_ms_nxt;

  // phase unit operands
  logic [31:0] div_r, div_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] on_ms_r, on_ms_nxt;
  logic [7:0]  sel_on_col_r, sel_on_col_nxt;
  logic [7:0]  sel_off_col_r, sel_off_col_nxt;
  logic        showing_r, showing_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_color_r, out_color_nxt;
  logic        out_showing_r, out_showing_nxt;

  // combinational helpers
  logic [31:0] elapsed;
  logic        use_tmp;
  logic [7:0]  src_on_units, src_off_units;
  logic [15:0] src_on_ms, src_period;
  logic [16:0] trial;
  logic        trial_ge;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_showing_r;

  // block choice: elapsed time against the armed lifetime
  assign elapsed = item_r.now_ms - tmp_start_ms_r;
  assign use_tmp = tmp_active_r && (tmp_duration_ms_r != 23'd0)
                   && (elapsed < {9'd0, tmp_duration_ms_r});
  assign src_on_units  = use_tmp ? tmp_on_time_r  : perm_on_time_r;
  assign src_off_units = use_tmp ? tmp_off_time_r : perm_off_time_r;
  assign src_on_ms  = 16'(src_on_units) * 16'(MS_PER_UNIT);
  assign src_period = src_on_ms + 16'(src_off_units) * 16'(MS_PER_UNIT);

  // one restoring remainder step
  assign trial    = {rem_r, div_r[31]};
  assign trial_ge = (trial >= {1'b0, period_r});

  // next-state logic
  always_comb begin
    state_nxt           = state_r;
    cnt_nxt             = cnt_r;
    item_nxt            = item_r;
    code_nxt            = code_r;
    perm_on_col_nxt     = perm_on_col_r;
    perm_off_col_nxt    = perm_off_col_r;
    perm_on_time_nxt    = perm_on_time_r;
    perm_off_time_nxt   = perm_off_time_r;
    tmp_on_col_nxt      = tmp_on_col_r;
    tmp_off_col_nxt     = tmp_off_col_r;
    tmp_on_time_nxt     = tmp_on_time_r;
    tmp_off_time_nxt    = tmp_off_time_r;
    tmp_active_nxt      = tmp_active_r;
    tmp_start_ms_nxt    = tmp_start_ms_r;
    tmp_duration_ms_nxt = tmp_duration_ms_r;
    div_nxt             = div_r;
    rem_nxt             = rem_r;
    period_nxt          = period_r;
    on_ms_nxt           = on_ms_r;
    sel_on_col_nxt      = sel_on_col_r;
    sel_off_col_nxt     = sel_off_col_r;
    showing_nxt         = showing_r;
    out_valid_nxt       = out_valid_r;
    out_color_nxt       = out_color_r;
    out_showing_nxt     = out_showing_r;

    // output drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt  = item_data_t'(in_tdata);
          code_nxt  = item_user_t'(in_tuser);
          state_nxt = S_APPLY;
        end
      end

      // apply the command record
      S_APPLY: begin
        if (code_r.perm_code == PERM_CODE_SET) begin
          perm_on_col_nxt   = item_r.perm_on_colour;
          perm_off_col_nxt  = item_r.perm_off_colour;
          perm_on_time_nxt  = item_r.perm_on_units;
          perm_off_time_nxt = item_r.perm_off_units;
        end
        if (code_r.temp_code == TEMP_CODE_CANCEL) begin
          tmp_active_nxt = 1'b0;
        end else if (code_r.temp_code == TEMP_CODE_SET) begin
          tmp_on_col_nxt      = item_r.temp_on_colour;
          tmp_off_col_nxt     = item_r.temp_off_colour;
          tmp_on_time_nxt     = item_r.temp_on_units;
          tmp_off_time_nxt    = item_r.temp_off_units;
          tmp_active_nxt      = 1'b1;
          tmp_start_ms_nxt    = item_r.now_ms;
          tmp_duration_ms_nxt = 23'(item_r.temp_timer_units) * 23'(MS_PER_UNIT);
        end
        state_nxt = S_SELECT;
      end

      // pick the deciding block and load the phase unit
      S_SELECT: begin
        showing_nxt     = use_tmp;
        sel_on_col_nxt  = use_tmp ? tmp_on_col_r  : perm_on_col_r;
        sel_off_col_nxt = use_tmp ? tmp_off_col_r : perm_off_col_r;
        div_nxt         = use_tmp ? elapsed : item_r.now_ms;
        on_ms_nxt       = src_on_ms;
        period_nxt      = src_period;
        rem_nxt         = 16'd0;
        cnt_nxt         = 5'd0;
        state_nxt       = (src_period == 16'd0) ? S_DONE : S_DIVIDE;
      end

      // remainder by period, one dividend bit per cycle
      S_DIVIDE: begin
        rem_nxt = trial_ge ? 16'(trial - {1'b0, period_r}) : trial[15:0];
        div_nxt = {div_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_DONE;
        end
      end

      // phase decides the colour; wait for room in the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_showing_nxt = showing_r;
          out_color_nxt   = ((period_r == 16'd0) || (rem_r < on_ms_r))
                            ? sel_on_col_r : sel_off_col_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      perm_on_col_r     <= '0;
      perm_off_col_r    <= '0;
      perm_on_time_r    <= '0;
      perm_off_time_r   <= '0;
      tmp_on_col_r      <= '0;
      tmp_off_col_r     <= '0;
      tmp_on_time_r     <= '0;
      tmp_off_time_r    <= '0;
      tmp_active_r      <= 1'b0;
      tmp_start_ms_r    <= '0;
      tmp_duration_ms_r <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      perm_on_col_r     <= perm_on_col_nxt;
      perm_off_col_r    <= perm_off_col_nxt;
      perm_on_time_r    <= perm_on_time_nxt;
      perm_off_time_r   <= perm_off_time_nxt;
      tmp_on_col_r      <= tmp_on_col_nxt;
      tmp_off_col_r     <= tmp_off_col_nxt;
      tmp_on_time_r     <= tmp_on_time_nxt;
      tmp_off_time_r    <= tmp_off_time_nxt;
      tmp_active_r      <= tmp_active_nxt;
      tmp_start_ms_r    <= tmp_start_ms_nxt;
      tmp_duration_ms_r <= tmp_duration_ms_nxt;
      out_valid_r       <= out_valid_nxt;
    end
    // payload, no reset needed
    cnt_r         <= cnt_nxt;
    item_r        <= item_nxt;
    code_r        <= code_nxt;
    div_r         <= div_nxt;
    rem_r         <= rem_nxt;
    period_r      <= period_nxt;
    on_ms_r       <= on_ms_nxt;
    sel_on_col_r  <= sel_on_col_nxt;
    sel_off_col_r <= sel_off_col_nxt;
    showing_r     <= showing_nxt;
    out_color_r   <= out_color_nxt;
    out_showing_r <= out_showing_nxt;
  end

  // assertions
  `LEDFSR_ASSERT_NEXT(a_busy_after_item, in_tvalid && in_tready, !in_tready, "ready after item")
  `LEDFSR_ASSERT_HOLDS(a_rem_range, state_r == S_DIVIDE, rem_r < period_r, "remainder >= period")
  `LEDFSR_ASSERT_HOLDS(a_res_done, $rose(out_valid_r), $past(state_r) == S_DONE, "stray result")

endmodule
